@@ rtl/knn_pkg.sv @@
// Shared types and constants for the k-nearest-neighbor average interpolator.
`timescale 1ns / 1ps
package knn_pkg;
  localparam int CoordWidth = 32;
  localparam int DistWidth  = 64;
  localparam int MAX_POINTS    = 256;
  localparam int MAX_NEIGHBORS = 16;
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EXACT = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;
  localparam logic REG_NEIGHBORS = 1'b0;
  localparam logic REG_DIMS      = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic signed [CoordWidth-1:0] coord_0;
    logic signed [CoordWidth-1:0] coord_1;
    logic signed [CoordWidth-1:0] coord_2;
    logic signed [CoordWidth-1:0] coord_3;
    logic signed [CoordWidth-1:0] sample_value;
  } req_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] result_value;
    logic [1:0] status;
    logic [4:0] neighbors_used;
    logic [8:0] stored_count;
  } rsp_t;
endpackage

@@ rtl/knn_if.sv @@
// Valid/ready channel carrying one payload of a chosen type.
`timescale 1ns / 1ps
interface knn_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/knn_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module knn_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/knn_average_interpolator.sv @@
// k-nearest-neighbor average interpolator: sample store, scan, sort and mean.
//
// Usage: requests arrive on the "req" channel (valid/ready), one result per
// request leaves on "rsp". Configuration writes (cfg_we, cfg_index, cfg_data)
// are to be made only while the block is idle; the block does not enforce this.
// Load, clear, no-op and empty-store requests: the result is valid the cycle
// after the request is accepted; no new request is taken while a result waits
// in the output register. A query has a start step, then for each stored
// sample an address step, a squaring step for each of the D dimensions and a
// compare; a sample that enters the sorted best list is shifted into place. An
// exact match ends the scan with a read of its value. Otherwise the k neighbor
// values are summed, then come a setup step, a restoring division and an output step.
// The block handles one request at a time; the result sits in an output
// register and a stalled receiver holds the block until it is taken.
// Reset (rst, synchronous) empties the store and sets neighbor_count to 1 and
// dimension_count to 2. Memory contents are not cleared; only written
// entries are ever read.
`timescale 1ns / 1ps
module knn_average_interpolator (
  input  logic        clk,
  input  logic        rst,
  knn_if.sink         req,
  knn_if.source       rsp,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import knn_pkg::*;

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int KCW = $clog2(MAX_NEIGHBORS + 1);
  localparam int SW = 32 + KCW;

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DIST = 4'd2,
    S_SORT = 4'd3, S_SUMR = 4'd4, S_SUMA = 4'd5, S_DIV = 4'd6,
    S_OUT = 4'd7, S_EXRD = 4'd8, S_EXWT = 4'd9, S_DSET = 4'd10;

  logic [3:0] state;
  logic [4:0] neighbor_count;
  logic [2:0] dimension_count;
  logic [CW-1:0] total;
  req_t q;
  rsp_t out;
  rsp_t start_rsp;
  logic out_valid;

  // memories
  logic we;
  logic [PW-1:0] waddr, raddr;
  logic [127:0] coord_rd;
  logic [31:0] val_rd;
  logic [PW-1:0] raddr_c, raddr_v;

  knn_ram #(.Width(128), .Depth(MAX_POINTS)) u_coord (
    .clk, .we, .waddr,
    .wdata({req.data.coord_3, req.data.coord_2, req.data.coord_1, req.data.coord_0}),
    .raddr(raddr_c), .rdata(coord_rd));
  knn_ram #(.Width(32), .Depth(MAX_POINTS)) u_val (
    .clk, .we, .waddr, .wdata(req.data.sample_value),
    .raddr(raddr_v), .rdata(val_rd));

  // best list (small, fixed-place registers shifted one step a cycle)
  logic [DistWidth-1:0] bd [MAX_NEIGHBORS];
  logic [PW-1:0] bi [MAX_NEIGHBORS];
  logic [KCW-1:0] filled, k, pos, sidx;
  logic [CW-1:0] scan;
  logic [2:0] dims;
  logic [2:0] dcnt;
  logic [DistWidth-1:0] cur_dist;
  logic [PW-1:0] cur;
  logic signed [SW-1:0] sum;
  logic [5:0] dstep;
  logic [SW-1:0] rem_acc, mag;
  logic neg;
  logic [5:0] k_lim;
  logic [2:0] dims_lim;

  assign we = req.valid && req.ready && req.data.op == OP_LOAD && total < CW'(MAX_POINTS);
  assign waddr = total[PW-1:0];
  assign raddr_c = scan[PW-1:0];
  assign raddr_v = (state == S_SUMR) ? bi[sidx[KW-1:0]] : raddr;
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  // result for requests that finish right away, and clamped query settings
  always_comb begin
    start_rsp = '0;
    start_rsp.stored_count = 9'(total);
    case (req.data.op)
      OP_LOAD: begin
        if (total < CW'(MAX_POINTS)) start_rsp.stored_count = 9'(total + 1'b1);
        else start_rsp.status = ST_FULL;
      end
      OP_CLEAR: start_rsp.stored_count = '0;
      OP_QUERY: if (total == '0) start_rsp.status = ST_EMPTY;
      default: ;
    endcase
    k_lim = (neighbor_count == '0) ? 6'd1 : 6'(neighbor_count);
    if (k_lim > 6'(MAX_NEIGHBORS)) k_lim = 6'(MAX_NEIGHBORS);
    if (CW'(k_lim) > total) k_lim = 6'(total);
    dims_lim = (dimension_count == '0) ? 3'd1 :
               (dimension_count > 3'd4) ? 3'd4 : dimension_count;
  end

  // per-dimension square, one dimension a cycle, summed into a registered distance
  logic signed [32:0] diff;
  logic [31:0] dmag;
  logic [63:0] sq;
  logic [64:0] acc;
  logic [DistWidth-1:0] dist_sum;
  always_comb begin
    case (dcnt[1:0])
      2'd0: diff = 33'(q.coord_0) - 33'($signed(coord_rd[31:0]));
      2'd1: diff = 33'(q.coord_1) - 33'($signed(coord_rd[63:32]));
      2'd2: diff = 33'(q.coord_2) - 33'($signed(coord_rd[95:64]));
      default: diff = 33'(q.coord_3) - 33'($signed(coord_rd[127:96]));
    endcase
    dmag = diff[32] ? 32'(-diff) : diff[31:0];
    sq   = 64'(dmag) * 64'(dmag);
    acc  = 65'(cur_dist) + 65'(sq);
    dist_sum = acc[64] ? '1 : acc[63:0];
  end

  logic [SW:0] trial;
  assign trial = {rem_acc[SW-2:0], mag[SW-1]} - {1'b0, (SW-KCW)'(0), k};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; total <= '0;
      neighbor_count <= 5'd1; dimension_count <= 3'd2;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NEIGHBORS) neighbor_count <= cfg_data;
        else dimension_count <= cfg_data[2:0];
      end
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (req.valid && req.ready) begin
          q <= req.data;
          out <= start_rsp;
          case (req.data.op)
            OP_LOAD: begin
              if (total < CW'(MAX_POINTS)) total <= total + 1'b1;
              out_valid <= 1'b1;
            end
            OP_CLEAR: begin
              total <= '0; out_valid <= 1'b1;
            end
            OP_QUERY: begin
              if (total == '0) begin
                out_valid <= 1'b1;
              end else begin
                dims <= dims_lim;
                k <= KCW'(k_lim);
                scan <= '0; filled <= '0; state <= S_SCAN;
              end
            end
            default: out_valid <= 1'b1;
          endcase
        end
        S_SCAN: begin // memory read in flight
          cur_dist <= '0; dcnt <= '0; cur <= scan[PW-1:0];
          state <= S_DIST;
        end
        S_DIST: begin
          cur_dist <= dist_sum;
          dcnt <= dcnt + 1'b1;
          if (dcnt + 1'b1 == dims) begin
            state <= S_SORT;
            if (dist_sum != '0 && filled == k && dist_sum >= bd[KW'(k - 1'b1)])
              pos <= '1; // skip insertion
            else
              pos <= (filled < k) ? filled : KCW'(k - 1'b1);
            if (dist_sum != '0 && filled < k) filled <= filled + 1'b1;
          end
        end
        S_SORT: begin
          if (cur_dist == '0) begin
            raddr <= cur; state <= S_EXRD;
          end else if (pos == '1) begin
            scan <= scan + 1'b1;
            if (scan + 1'b1 == total) begin sidx <= '0; sum <= '0; state <= S_SUMR; end
            else state <= S_SCAN;
          end else if (pos != '0 && bd[KW'(pos - 1'b1)] > cur_dist) begin
            bd[pos[KW-1:0]] <= bd[KW'(pos - 1'b1)];
            bi[pos[KW-1:0]] <= bi[KW'(pos - 1'b1)];
            pos <= pos - 1'b1;
          end else begin
            bd[pos[KW-1:0]] <= cur_dist; bi[pos[KW-1:0]] <= cur;
            pos <= '1;
          end
        end
        S_EXRD: state <= S_EXWT;
        S_EXWT: begin
          out.result_value <= val_rd; out.status <= ST_EXACT;
          out.neighbors_used <= 5'd1; out_valid <= 1'b1; state <= S_IDLE;
        end
        S_SUMR: state <= S_SUMA;
        S_SUMA: begin
          sum <= sum + SW'($signed(val_rd));
          if (sidx + 1'b1 == k) state <= S_DSET;
          else begin sidx <= sidx + 1'b1; state <= S_SUMR; end
        end
        S_DSET: begin
          neg <= sum[SW-1];
          mag <= sum[SW-1] ? SW'(-sum) : SW'(sum);
          rem_acc <= '0; dstep <= '0; state <= S_DIV;
        end
        S_DIV: begin
          if (!trial[SW]) rem_acc <= trial[SW-1:0];
          else rem_acc <= {rem_acc[SW-2:0], mag[SW-1]};
          mag <= {mag[SW-2:0], !trial[SW]};
          dstep <= dstep + 1'b1;
          if (dstep == 6'(SW - 1)) state <= S_OUT;
        end
        S_OUT: begin
          out.result_value <= neg ? -mag[31:0] : mag[31:0];
          out.neighbors_used <= 5'(k); out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_POINTS)) else $error("store count overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready) else $error("ready while busy");
  a_k: assert property (@(posedge clk) disable iff (rst)
    state == S_SUMA |-> k != '0) else $error("zero neighbor count");
`endif
endmodule
